/* design/wsp_pkg.sv */
// Shared types, constants and helpers for the warp starfield projector.
// No dependencies; every other design file but wsp_ram imports this package.
`default_nettype none
package wsp_pkg;

    localparam int NUM_STARS   = 64;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int XY_W        = 14;
    localparam int DEPTH_W     = 13;
    localparam int STAR_W      = 2 * XY_W + DEPTH_W;
    localparam int REG_W       = 13;
    localparam int DIV_W       = 24;
    localparam int DIV_CNT_W   = $clog2(DIV_W);

    localparam logic [31:0]        SEED_MULT  = 32'd2654435761;
    localparam logic [DEPTH_W-1:0] WRAP_DEPTH = 13'd4096;
    localparam logic [DEPTH_W-1:0] NEAR_STEP  = 13'd6;
    localparam logic [DEPTH_W-1:0] DEPTH_BASE = 13'd256;
    localparam logic [XY_W-1:0]    XY_BIAS    = 14'd4096;
    localparam logic [3:0]         COLOR_DIM  = 4'd7;
    localparam logic [3:0]         COLOR_BRT  = 4'd15;

    localparam logic [REG_W-1:0] WIDTH_RST  = 13'd320;
    localparam logic [REG_W-1:0] HEIGHT_RST = 13'd200;
    localparam logic [REG_W-1:0] PITCH_RST  = 13'd320;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PITCH  = 2'd2;

    localparam logic KIND_SEED  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] planet_id;
    } wsp_in_t;

    typedef struct packed {
        logic        visible;
        logic [23:0] pixel_offset;
        logic [3:0]  color;
        logic        last;
    } wsp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_RD,
        ST_UPD,
        ST_DIV,
        ST_PROJ,
        ST_MUL,
        ST_EMIT
    } wsp_state_t;

    // controller -> datapath
    typedef struct packed {
        logic             load_seed;
        logic             draw;
        logic [1:0]       phase;
        logic             upd;
        logic             div_step;
        logic             proj;
        logic             mul;
        logic             emit;
        logic             dim;
        logic             last;
        logic [IDX_W-1:0] idx;
    } wsp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_room;
    } wsp_sts_t;

    // one xorshift32 step (13, 17, 5)
    function automatic logic [31:0] next_draw(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage
`default_nettype wire

/* design/warp_starfield_projector_top.sv */
// Top level of the warp starfield projector: controller plus datapath.
// Depends on wsp_pkg, wsp_ctrl, wsp_dp (and wsp_ram through wsp_dp).
//
// Takes one transaction at a time. A seed transaction (kind 0) draws x,
// y and depth for each star and gives no results. A frame transaction
// (kind 1) takes each star through read, update, the 24-step serial
// dividers (x and y in parallel), projection, row multiply and emit,
// which waits while the output is stalled. The block returns to idle
// before it takes the next transaction. Results leave one per star in
// table order through an output register; in_stall is high while an item is
// in progress. Configuration writes are taken at any time but are meant to
// land while the block is idle.
`default_nettype none
module warp_starfield_projector_top
    import wsp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire wsp_in_t          in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output wsp_out_t              out_data,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [REG_W-1:0] cfg_data
);

    wsp_cmd_t cmd;
    wsp_sts_t sts;
    logic     busy;

    assign in_stall = busy;

    wsp_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(in_valid && !busy),
        .kind (in_data.kind),
        .sts  (sts),
        .busy (busy),
        .cmd  (cmd)
    );

    wsp_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .planet_id(in_data.planet_id),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .out_data (out_data),
        .sts      (sts)
    );

endmodule
`default_nettype wire

/* design/wsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

/* design/wsp_ctrl.sv */
// Sequencer for seeding and frame projection; drives the datapath by command.
// Depends on wsp_pkg.
`default_nettype none
module wsp_ctrl
    import wsp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     kind,
    input  wire wsp_sts_t sts,
    output logic          busy,
    output wsp_cmd_t      cmd
);

    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(NUM_STARS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    wsp_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [1:0]           phase_reg, phase_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]           mod3_reg, mod3_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            phase_reg <= '0;
            cnt_reg   <= '0;
            mod3_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            mod3_reg  <= mod3_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        mod3_next    = mod3_reg;
        cmd          = '0;
        cmd.idx      = idx_reg;
        cmd.phase    = phase_reg;
        cmd.dim      = (mod3_reg == 2'd0);
        cmd.last     = (idx_reg == LAST_IDX);
        busy         = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next   = '0;
                phase_next = '0;
                mod3_next  = '0;
                if (start)
                begin
                    if (kind == KIND_SEED)
                    begin
                        cmd.load_seed = 1'b1;
                        state_next    = ST_SEED;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_SEED:
            begin
                cmd.draw = 1'b1;
                if (phase_reg == 2'd2)
                begin
                    phase_next = '0;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_RD:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_PROJ;
                end
            end
            ST_PROJ:
            begin
                cmd.proj   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_room)
                begin
                    cmd.emit  = 1'b1;
                    mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/wsp_dp.sv */
// Datapath: config registers, star table, generator, serial dividers, output register.
// Depends on wsp_pkg and wsp_ram.
`default_nettype none
module wsp_dp
    import wsp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire wsp_cmd_t         cmd,
    input  wire logic [15:0]      planet_id,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [REG_W-1:0] cfg_data,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output wsp_out_t              out_data,
    output wsp_sts_t              sts
);

    // configuration registers
    logic [REG_W-1:0] width_reg, height_reg, pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            pitch_reg  <= PITCH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_PITCH:  pitch_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic [REG_W-2:0] cx, cy;
    assign cx = width_reg[REG_W-1:1];
    assign cy = height_reg[REG_W-1:1];

    // generator
    logic [31:0]     rng_reg;
    logic [31:0]     draw_val;
    logic [XY_W-1:0] sx_seed_reg, sy_seed_reg;
    logic [16:0]     id_inc;
    logic [48:0]     seed_prod;

    assign draw_val  = next_draw(rng_reg);
    assign id_inc    = {1'b0, planet_id} + 17'd1;
    assign seed_prod = id_inc * SEED_MULT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg <= '0;
        end
        else if (cmd.load_seed)
        begin
            rng_reg <= seed_prod[31:0];
        end
        else if (cmd.draw)
        begin
            rng_reg <= draw_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.draw && cmd.phase == 2'd0)
        begin
            sx_seed_reg <= {1'b0, draw_val[12:0]} - XY_BIAS;
        end
        if (cmd.draw && cmd.phase == 2'd1)
        begin
            sy_seed_reg <= {1'b0, draw_val[12:0]} - XY_BIAS;
        end
    end

    // star table and per-entry valid bits
    logic                   ram_we;
    logic [STAR_W-1:0]      ram_wdata, ram_rdata;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   rd_valid_reg;
    logic [XY_W-1:0]        star_x, star_y;
    logic [DEPTH_W-1:0]     star_d, d_new;
    logic [DEPTH_W:0]       d_dec;

    assign star_x = rd_valid_reg ? ram_rdata[STAR_W-1 -: XY_W] : '0;
    assign star_y = rd_valid_reg ? ram_rdata[DEPTH_W +: XY_W] : '0;
    assign star_d = rd_valid_reg ? ram_rdata[DEPTH_W-1:0] : '0;
    assign d_dec  = {1'b0, star_d} - {1'b0, NEAR_STEP};
    assign d_new  = ($signed(d_dec) < 14'sd1) ? WRAP_DEPTH : d_dec[DEPTH_W-1:0];

    logic seed_wr;
    assign seed_wr = cmd.draw && cmd.phase == 2'd2;
    assign ram_we  = seed_wr || cmd.upd;

    always_comb
    begin
        if (seed_wr)
        begin
            ram_wdata = {sx_seed_reg, sy_seed_reg, DEPTH_BASE + {1'b0, draw_val[11:0]}};
        end
        else
        begin
            ram_wdata = {star_x, star_y, d_new};
        end
    end

    wsp_ram #(
        .WIDTH(STAR_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(cmd.idx),
        .wdata(ram_wdata),
        .raddr(cmd.idx),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[cmd.idx];
            if (ram_we)
            begin
                valid_reg[cmd.idx] <= 1'b1;
            end
        end
    end

    // products and restoring dividers, one quotient bit per cycle each
    logic signed [26:0]  px_prod, py_prod;
    logic [26:0]         px_mag, py_mag;
    logic                xneg_reg, yneg_reg;
    logic [DIV_W-1:0]    qx_reg, qy_reg;
    logic [DEPTH_W-1:0]  remx_reg, remy_reg, div_d_reg;
    logic [DEPTH_W:0]    remx_t, remy_t;

    assign px_prod = $signed(star_x) * $signed({1'b0, cx});
    assign py_prod = $signed(star_y) * $signed({1'b0, cy});
    assign px_mag  = px_prod[26] ? 27'(-px_prod) : px_prod;
    assign py_mag  = py_prod[26] ? 27'(-py_prod) : py_prod;
    assign remx_t  = {remx_reg, qx_reg[DIV_W-1]};
    assign remy_t  = {remy_reg, qy_reg[DIV_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            xneg_reg  <= px_prod[26];
            yneg_reg  <= py_prod[26];
            qx_reg    <= px_mag[DIV_W-1:0];
            qy_reg    <= py_mag[DIV_W-1:0];
            remx_reg  <= '0;
            remy_reg  <= '0;
            div_d_reg <= d_new;
        end
        else if (cmd.div_step)
        begin
            if (remx_t >= {1'b0, div_d_reg})
            begin
                remx_reg <= 13'(remx_t - {1'b0, div_d_reg});
                qx_reg   <= {qx_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                remx_reg <= remx_t[DEPTH_W-1:0];
                qx_reg   <= {qx_reg[DIV_W-2:0], 1'b0};
            end
            if (remy_t >= {1'b0, div_d_reg})
            begin
                remy_reg <= 13'(remy_t - {1'b0, div_d_reg});
                qy_reg   <= {qy_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                remy_reg <= remy_t[DEPTH_W-1:0];
                qy_reg   <= {qy_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    // projection about the centre, visibility, then row offset
    logic signed [DIV_W+1:0] sx_c, sy_c;
    logic signed [DIV_W+1:0] qx_s, qy_s;
    logic [12:0]             sx_reg, sy_reg;
    logic                    vis_reg;
    logic [24:0]             row_off_reg;
    logic [25:0]             row_prod;
    logic [24:0]             off_sum;

    assign qx_s = xneg_reg ? -$signed({2'b00, qx_reg}) : $signed({2'b00, qx_reg});
    assign qy_s = yneg_reg ? -$signed({2'b00, qy_reg}) : $signed({2'b00, qy_reg});
    assign sx_c = $signed({14'd0, cx}) + qx_s;
    assign sy_c = $signed({14'd0, cy}) + qy_s;

    // screen coordinates reach 13 bits when the canvas is wider than 4096
    assign row_prod = {13'd0, sy_reg} * {13'd0, pitch_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.proj)
        begin
            vis_reg <= !sx_c[DIV_W+1] && !sy_c[DIV_W+1]
                && (sx_c < $signed({13'd0, width_reg}))
                && (sy_c < $signed({13'd0, height_reg}));
            sx_reg  <= sx_c[12:0];
            sy_reg  <= sy_c[12:0];
        end
        if (cmd.mul)
        begin
            row_off_reg <= row_prod[24:0];
        end
    end

    assign off_sum = row_off_reg + {12'd0, sx_reg};

    // output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data.visible      <= vis_reg;
            out_data.pixel_offset <= vis_reg ? off_sum[23:0] : '0;
            out_data.color        <= cmd.dim ? COLOR_DIM : COLOR_BRT;
            out_data.last         <= cmd.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.out_room = !out_valid_reg || !out_stall;

endmodule
`default_nettype wire

/* tb/tb_warp_starfield_projector_top.sv */
// Self-checking testbench for warp_starfield_projector_top.
// Depends on wsp_pkg and the design; predicts star seeding and frame projection
// in behavioral code and checks every frame result under random idle and stall.
`timescale 1ns / 1ps
`default_nettype none
module tb_warp_starfield_projector_top;
    import wsp_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    wsp_in_t          in_data;
    logic             out_valid;
    logic             out_stall;
    wsp_out_t         out_data;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [REG_W-1:0] cfg_data;

    warp_starfield_projector_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // star table and canvas registers as the block should hold them
    int          sky_x [NUM_STARS];
    int          sky_y [NUM_STARS];
    int          sky_depth [NUM_STARS];
    logic [31:0] gen_state;
    logic [REG_W-1:0] canvas_w, canvas_h, canvas_pitch;

    wsp_in_t  pending_items [$];
    wsp_out_t expected_pixels [$];

    int  mismatch_cnt;
    int  pixels_seen;
    int  seeds_sent;
    int  frames_sent;
    int  gap_left;
    int  hold_left;
    logic long_hold_req;
    logic long_hold_done;

    // xorshift32 step, shifts 13, 17, 5
    function automatic logic [31:0] rng_step(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic void seed_table(input logic [15:0] planet);
        logic [31:0] s;
        s = ({16'd0, planet} + 32'd1) * SEED_MULT;
        for (int i = 0; i < NUM_STARS; i++)
        begin
            s = rng_step(s);
            sky_x[i] = int'(s & 32'h1FFF) - 4096;
            s = rng_step(s);
            sky_y[i] = int'(s & 32'h1FFF) - 4096;
            s = rng_step(s);
            sky_depth[i] = 256 + int'(s & 32'hFFF);
        end
        gen_state = s;
    endfunction

    // move every star closer and queue its projected pixel
    function automatic void render_frame();
        longint   w, h, cx, cy, px, py, off;
        wsp_out_t pix;
        w  = longint'(canvas_w);
        h  = longint'(canvas_h);
        cx = w >>> 1;
        cy = h >>> 1;
        for (int i = 0; i < NUM_STARS; i++)
        begin
            sky_depth[i] = sky_depth[i] - 6;
            if (sky_depth[i] < 1)
                sky_depth[i] = 4096;
            px = cx + (longint'(sky_x[i]) * cx) / longint'(sky_depth[i]);
            py = cy + (longint'(sky_y[i]) * cy) / longint'(sky_depth[i]);
            pix.visible = (px >= 0 && px < w && py >= 0 && py < h);
            off = pix.visible ? (py * longint'(canvas_pitch) + px) : 0;
            pix.pixel_offset = off[23:0];
            pix.color = (i % 3 == 0) ? COLOR_DIM : COLOR_BRT;
            pix.last = (i == NUM_STARS - 1);
            expected_pixels.push_back(pix);
        end
    endfunction

    function automatic void note_mismatch(input string field, input longint exp_v,
                                          input longint act_v);
        if (mismatch_cnt < 10)
            $display("mismatch at pixel %0d, %s: expected %0d, got %0d",
                     pixels_seen, field, exp_v, act_v);
        mismatch_cnt++;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // input driver: offers queued transactions with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        logic    nxt_valid;
        wsp_in_t nxt_data;
        int      r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_data  = in_data;
            if (in_valid && !in_stall)
            begin
                if (in_data.kind == KIND_SEED)
                begin
                    seed_table(in_data.planet_id);
                    seeds_sent++;
                end
                else
                begin
                    render_frame();
                    frames_sent++;
                end
                nxt_valid = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 50)
                    gap_left <= 0;
                else if (r < 85)
                    gap_left <= $urandom_range(1, 3);
                else
                    gap_left <= $urandom_range(10, 60);
            end
            else if (!in_valid)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_items.size() > 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_data  = pending_items.pop_front();
                end
            end
            in_valid <= nxt_valid;
            in_data  <= nxt_data;
        end
    end

    // output stall: short random stalls, one long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        int r;
        if (!rst_n)
        begin
            out_stall      <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= 3000;
            out_stall      <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                out_stall <= 1'b0;
            else if (r < 95)
            begin
                out_stall <= 1'b1;
                hold_left <= $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                hold_left <= $urandom_range(10, 40);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        wsp_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
                note_mismatch("unexpected transaction", 0, 1);
            else
            begin
                want = expected_pixels.pop_front();
                if (out_data.visible !== want.visible)
                    note_mismatch("visible", want.visible, out_data.visible);
                if (out_data.pixel_offset !== want.pixel_offset)
                    note_mismatch("pixel_offset", want.pixel_offset,
                                  out_data.pixel_offset);
                if (out_data.color !== want.color)
                    note_mismatch("color", want.color, out_data.color);
                if (out_data.last !== want.last)
                    note_mismatch("last", want.last, out_data.last);
            end
            pixels_seen++;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_WIDTH:  canvas_w     = val;
            REG_HEIGHT: canvas_h     = val;
            REG_PITCH:  canvas_pitch = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for all queued work to finish, then let a seed run out
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic void queue_item(input logic kind, input logic [15:0] planet);
        wsp_in_t it;
        it.kind      = kind;
        it.planet_id = planet;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_random(input int n);
        for (int i = 0; i < n; i++)
            queue_item(($urandom_range(0, 99) < 35) ? KIND_SEED : KIND_FRAME,
                       16'($urandom));
    endfunction

    // stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        long_hold_req = 1'b0;
        mismatch_cnt = 0;
        pixels_seen = 0;
        seeds_sent = 0;
        frames_sent = 0;
        for (int i = 0; i < NUM_STARS; i++)
        begin
            sky_x[i] = 0;
            sky_y[i] = 0;
            sky_depth[i] = 0;
        end
        gen_state = '0;
        canvas_w = WIDTH_RST;
        canvas_h = HEIGHT_RST;
        canvas_pitch = PITCH_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: frame before any seed, extreme planet numbers
        queue_item(KIND_FRAME, 16'hFFFF);
        queue_item(KIND_SEED, 16'h0000);
        queue_item(KIND_FRAME, 16'h0000);
        queue_item(KIND_FRAME, 16'h5A5A);
        queue_item(KIND_SEED, 16'hFFFF);
        queue_item(KIND_FRAME, 16'hFFFF);
        drain();

        // zero canvas: nothing visible; unused index is ignored
        write_reg(REG_WIDTH, 13'd0);
        write_reg(REG_HEIGHT, 13'd0);
        write_reg(2'd3, 13'h1FFF);
        queue_item(KIND_SEED, 16'd7);
        queue_item(KIND_FRAME, 16'd0);
        drain();

        // smallest canvas
        write_reg(REG_WIDTH, 13'd1);
        write_reg(REG_HEIGHT, 13'd1);
        write_reg(REG_PITCH, 13'd1);
        queue_item(KIND_FRAME, 16'd0);
        queue_random(20);
        drain();

        // largest canvas, with a long output hold while input keeps coming
        write_reg(REG_WIDTH, 13'd4096);
        write_reg(REG_HEIGHT, 13'd4096);
        write_reg(REG_PITCH, 13'd4096);
        queue_random(25);
        @(posedge clk);
        long_hold_req <= 1'b1;
        drain();

        // all-ones register values
        write_reg(REG_WIDTH, 13'h1FFF);
        write_reg(REG_HEIGHT, 13'h1FFF);
        write_reg(REG_PITCH, 13'h1FFF);
        queue_random(20);
        drain();

        // random canvases
        for (int p = 0; p < 3; p++)
        begin
            write_reg(REG_WIDTH, 13'($urandom_range(1, 4096)));
            write_reg(REG_HEIGHT, 13'($urandom_range(1, 4096)));
            write_reg(REG_PITCH, 13'($urandom_range(1, 4096)));
            write_reg(2'd3, 13'($urandom));
            queue_random(20);
            drain();
        end

        $display("covered %0d seed and %0d frame transactions, %0d pixels checked,",
                 seeds_sent, frames_sent, pixels_seen);
        $display("over zero, minimum, maximum, all-ones and random canvas settings");
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches in total", mismatch_cnt);
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #100ms;
        $display("timeout");
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
